FILE: sv/blr_pkg.sv
// Shared types and constants of the line rasterizer.
package blr_pkg;

  localparam int unsigned CoordW    = 6;
  localparam int unsigned CharW     = 8;
  localparam int unsigned CanvasW   = 7;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned ErrW      = 10;

  localparam int unsigned MaxSideDefault = 64;

  localparam logic [CanvasW-1:0] CanvasReset = 7'd64;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgCanvasWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCanvasHeight = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic final_pt;
  } sts_t;

endpackage

FILE: sv/blr_ctrl.sv
// Controller state machine of the line rasterizer.
module blr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  blr_pkg::sts_t sts_i,
  output blr_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o.load  = 1'b0;
    cmd_o.emit  = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.final_pt) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/blr_datapath.sv
// Datapath of the line rasterizer: walk registers, error term and result register.
module blr_datapath #(
  parameter int unsigned MAX_SIDE = blr_pkg::MaxSideDefault
) (
  input  logic                         clk_i,
  input  blr_pkg::cmd_t                cmd_i,
  output blr_pkg::sts_t                sts_o,
  input  logic [blr_pkg::CoordW-1:0]   start_x_i,
  input  logic [blr_pkg::CoordW-1:0]   start_y_i,
  input  logic [blr_pkg::CoordW-1:0]   end_x_i,
  input  logic [blr_pkg::CoordW-1:0]   end_y_i,
  input  logic [blr_pkg::CharW-1:0]    fill_char_i,
  input  logic [blr_pkg::CanvasW-1:0]  canvas_width_i,
  input  logic [blr_pkg::CanvasW-1:0]  canvas_height_i,
  output logic [blr_pkg::CoordW-1:0]   pixel_x_o,
  output logic [blr_pkg::CoordW-1:0]   pixel_y_o,
  output logic [blr_pkg::CharW-1:0]    pixel_char_o,
  output logic                         visible_o,
  output logic                         last_point_o
);

  localparam int unsigned CntW = $clog2(MAX_SIDE);
  localparam int unsigned CW   = blr_pkg::CoordW;
  localparam int unsigned EW   = blr_pkg::ErrW;
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_SIDE - 1);

  logic [CW-1:0]             px_q, py_q, tx_q, ty_q, dx_q, ady_q;
  logic [CW-1:0]             px_d, py_d, dx_d, ady_d;
  logic                      sx_neg_q, sy_neg_q;
  logic [blr_pkg::CharW-1:0] ch_q;
  logic signed [EW-1:0]      err_q, err_d, e2, dx_e, dy_e;
  logic [CntW-1:0]           cnt_q;
  logic                      done, step_x, step_y;

  assign dx_d  = (start_x_i < end_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
  assign ady_d = (start_y_i < end_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;

  assign done = (px_q == tx_q) && (py_q == ty_q);
  assign sts_o.final_pt = done || (cnt_q == CntLast);

  // error step: e2 = 2 * err against dy (negative) and dx
  always_comb begin
    dx_e   = $signed({{(EW-CW){1'b0}}, dx_q});
    dy_e   = -$signed({{(EW-CW){1'b0}}, ady_q});
    e2     = err_q <<< 1;
    step_x = (e2 >= dy_e);
    step_y = (e2 <= dx_e);
    err_d  = err_q + (step_x ? dy_e : '0) + (step_y ? dx_e : '0);
    px_d   = px_q;
    py_d   = py_q;
    if (step_x) begin
      px_d = sx_neg_q ? px_q - 1'b1 : px_q + 1'b1;
    end
    if (step_y) begin
      py_d = sy_neg_q ? py_q - 1'b1 : py_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q     <= start_x_i;
      py_q     <= start_y_i;
      tx_q     <= end_x_i;
      ty_q     <= end_y_i;
      ch_q     <= fill_char_i;
      dx_q     <= dx_d;
      ady_q    <= ady_d;
      sx_neg_q <= !(start_x_i < end_x_i);
      sy_neg_q <= !(start_y_i < end_y_i);
      err_q    <= $signed({{(EW-CW){1'b0}}, dx_d}) - $signed({{(EW-CW){1'b0}}, ady_d});
      cnt_q    <= '0;
    end else if (cmd_i.emit) begin
      px_q  <= px_d;
      py_q  <= py_d;
      err_q <= err_d;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pixel_x_o    <= px_q;
      pixel_y_o    <= py_q;
      pixel_char_o <= ch_q;
      visible_o    <= ({1'b0, px_q} < canvas_width_i) && ({1'b0, py_q} < canvas_height_i);
      last_point_o <= done;
    end
  end

endmodule

FILE: sv/bresenham_line_rasterizer.sv
// Top level of the line rasterizer: configuration registers, controller and datapath.
//
// Usage: present a line command (start_x/start_y, end_x/end_y, fill_char) with
// in_valid_i; it transfers when in_ready_o is high. The block then walks the
// line with the integer error-term rule and delivers one pixel result per
// point on the out_valid_o/out_ready_i channel, both end points included, so
// a line gives max(|dx|,|dy|)+1 results (at most MAX_SIDE). last_point_o marks
// the second end point; visible_o is set when the point lies inside the canvas.
// The command loads the walk registers; each emit then copies the current
// point into the result register. Throughput: one pixel per cycle while the
// receiver takes them, set by the single error-term update in the datapath.
// A stalled receiver holds the result register and freezes the walk; nothing
// is dropped. The last result may still wait while the next command transfers.
// Reset: canvas width and height return to 64, the controller goes idle and
// any result in flight is dropped. Write the canvas registers only while idle.
module bresenham_line_rasterizer #(
  parameter int unsigned MAX_SIDE = blr_pkg::MaxSideDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [blr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [blr_pkg::CanvasW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [blr_pkg::CoordW-1:0]    start_x_i,
  input  logic [blr_pkg::CoordW-1:0]    start_y_i,
  input  logic [blr_pkg::CoordW-1:0]    end_x_i,
  input  logic [blr_pkg::CoordW-1:0]    end_y_i,
  input  logic [blr_pkg::CharW-1:0]     fill_char_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [blr_pkg::CoordW-1:0]    pixel_x_o,
  output logic [blr_pkg::CoordW-1:0]    pixel_y_o,
  output logic [blr_pkg::CharW-1:0]     pixel_char_o,
  output logic                          visible_o,
  output logic                          last_point_o
);

  logic [blr_pkg::CanvasW-1:0] canvas_width_q, canvas_height_q;
  blr_pkg::cmd_t               cmd;
  blr_pkg::sts_t               sts;

  // canvas registers; an index off the list has no register behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_width_q  <= blr_pkg::CanvasReset;
      canvas_height_q <= blr_pkg::CanvasReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        blr_pkg::CfgCanvasWidth:  canvas_width_q  <= cfg_data_i;
        blr_pkg::CfgCanvasHeight: canvas_height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // sequence the command load and one pixel transfer per free output slot
  blr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // hold the walk state, advance the error term and register each pixel
  blr_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .fill_char_i     (fill_char_i),
    .canvas_width_i  (canvas_width_q),
    .canvas_height_i (canvas_height_q),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_char_o    (pixel_char_o),
    .visible_o       (visible_o),
    .last_point_o    (last_point_o)
  );

`ifndef SYNTHESIS
  // a command transfer makes the block busy in the next cycle
  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("rasterizer still ready after command transfer");

  // the final point of a walk returns the block to idle
  a_idle_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit && sts.final_pt |=> in_ready_o)
    else $error("rasterizer not idle after final point");

  // no pixel is produced while waiting for a command
  a_no_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd.emit)
    else $error("pixel produced while idle");

  // a produced pixel shows up as a valid result in the next cycle
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_valid_o)
    else $error("produced pixel not presented");
`endif

endmodule

FILE: verif/tb_bresenham_line_rasterizer.sv
// Self-checking testbench for the line rasterizer: line commands in, checked pixels out.
module tb_bresenham_line_rasterizer;
  import blr_pkg::*;

  // Walk bound of the instance under test, and the idle time allowed after the
  // last expected pixel.
  localparam int unsigned WalkLimit    = MaxSideDefault;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldOffLen   = 400;
  localparam int unsigned ItemsPerRun  = 31;
  localparam int unsigned NumRuns      = 9;
  localparam int unsigned DrainBound   = 200000;

  typedef struct packed {
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y1;
    logic [CharW-1:0]  ch;
  } line_cmd_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CharW-1:0]  ch;
    logic              visible;
    logic              last;
  } pixel_t;

  // Holds its own copy of the canvas size, walks every accepted line into the
  // pixels it must produce, and matches the pixels the block hands over.
  class line_pixel_checker;
    int unsigned canvas_w;
    int unsigned canvas_h;
    int unsigned mismatches;
    pixel_t      pending_pixels[$];

    function new();
      canvas_w   = CanvasReset;
      canvas_h   = CanvasReset;
      mismatches = 0;
    endfunction

    function void set_canvas(input int unsigned w, input int unsigned h);
      canvas_w = w;
      canvas_h = h;
    endfunction

    function int unsigned pending();
      return pending_pixels.size();
    endfunction

    // Integer error-term walk from the first end point to the second.
    function void walk_line(input line_cmd_t c);
      int     px, py, tx, ty, dx, dy, sx, sy, err, e2;
      bit     done;
      pixel_t p;
      px  = c.x0;
      py  = c.y0;
      tx  = c.x1;
      ty  = c.y1;
      dx  = (tx > px) ? tx - px : px - tx;
      dy  = (ty > py) ? py - ty : ty - py;
      sx  = (px < tx) ? 1 : -1;
      sy  = (py < ty) ? 1 : -1;
      err = dx + dy;
      for (int n = 0; n < WalkLimit; n++) begin
        done      = (px == tx) && (py == ty);
        p.x       = px[CoordW-1:0];
        p.y       = py[CoordW-1:0];
        p.ch      = c.ch;
        p.visible = (px < int'(canvas_w)) && (py < int'(canvas_h));
        p.last    = done;
        pending_pixels.push_back(p);
        if (done) break;
        e2 = 2 * err;
        if (e2 >= dy) begin
          err += dy;
          px  += sx;
        end
        if (e2 <= dx) begin
          err += dx;
          py  += sy;
        end
      end
    endfunction

    function void note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_pixel(input pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        note_mismatch($sformatf("pixel with none pending: x=%0d y=%0d ch=%0h vis=%0b last=%0b",
                                got.x, got.y, got.ch, got.visible, got.last));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.x != want.x || got.y != want.y || got.ch != want.ch ||
          got.visible != want.visible || got.last != want.last)
        note_mismatch($sformatf(
          "exp x=%0d y=%0d ch=%0h vis=%0b last=%0b, got x=%0d y=%0d ch=%0h vis=%0b last=%0b",
          want.x, want.y, want.ch, want.visible, want.last,
          got.x, got.y, got.ch, got.visible, got.last));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_idx;
  logic [CanvasW-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [CoordW-1:0]    start_x, start_y, end_x, end_y;
  logic [CharW-1:0]     fill_char;
  logic                 out_valid;
  logic                 out_ready;
  logic [CoordW-1:0]    pixel_x, pixel_y;
  logic [CharW-1:0]     pixel_char;
  logic                 visible;
  logic                 last_point;

  line_pixel_checker board;
  bit                calm;          // no idling on either side while set
  bit                hold_off_req;  // asks the sink for one long hold-off

  bresenham_line_rasterizer DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .start_x_i    (start_x),
    .start_y_i    (start_y),
    .end_x_i      (end_x),
    .end_y_i      (end_y),
    .fill_char_i  (fill_char),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pixel_x_o    (pixel_x),
    .pixel_y_o    (pixel_y),
    .pixel_char_o (pixel_char),
    .visible_o    (visible),
    .last_point_o (last_point)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > 63) return 63;
    return v;
  endfunction

  function automatic line_cmd_t mk_line(input int x0, input int y0, input int x1,
                                        input int y1, input int ch);
    line_cmd_t c;
    c.x0 = x0[CoordW-1:0];
    c.y0 = y0[CoordW-1:0];
    c.x1 = x1[CoordW-1:0];
    c.y1 = y1[CoordW-1:0];
    c.ch = ch[CharW-1:0];
    return c;
  endfunction

  // Mix of arbitrary lines, short lines (quick back-to-back transfers) and
  // lines along an axis or a diagonal.
  function automatic line_cmd_t random_line();
    int unsigned kind;
    int          x0, y0, d;
    kind = $urandom_range(0, 9);
    x0   = $urandom_range(0, 63);
    y0   = $urandom_range(0, 63);
    if (kind < 6)
      return mk_line(x0, y0, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 255));
    if (kind < 9)
      return mk_line(x0, y0, clamp_coord(x0 + int'($urandom_range(0, 8)) - 4),
                     clamp_coord(y0 + int'($urandom_range(0, 8)) - 4), $urandom_range(0, 255));
    d = int'($urandom_range(0, 63)) - x0;
    case ($urandom_range(0, 2))
      0:       return mk_line(x0, y0, x0 + d, y0, $urandom_range(0, 255));
      1:       return mk_line(x0, y0, x0, $urandom_range(0, 63), $urandom_range(0, 255));
      default: return mk_line(x0, y0, x0 + d, clamp_coord(y0 + d), $urandom_range(0, 255));
    endcase
  endfunction

  // Offer one line and hold it until it transfers. Valid is left high; the
  // task drops it only when a gap follows, and the caller after its last line.
  task automatic send_line(input line_cmd_t c);
    int unsigned gap;
    in_valid  <= 1'b1;
    start_x   <= c.x0;
    start_y   <= c.y0;
    end_x     <= c.x1;
    end_y     <= c.y1;
    fill_char <= c.ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.walk_line(c);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for the last expected pixel, then let the block settle.
  task automatic wait_drained();
    int unsigned n;
    n = 0;
    while (board.pending() != 0 && n < DrainBound) begin
      @(posedge clk);
      n++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Both canvas registers in consecutive cycles; the block must be idle.
  task automatic write_canvas(input int unsigned w, input int unsigned h);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgCanvasWidth;
    cfg_data <= w[CanvasW-1:0];
    @(posedge clk);
    cfg_idx  <= CfgCanvasHeight;
    cfg_data <= h[CanvasW-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    board.set_canvas(w, h);
  endtask

  // Check every pixel that transfers; values sampled at the edge are the
  // ones the block presented before it.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_pixel({pixel_x, pixel_y, pixel_char, visible, last_point});
  end

  // Receiver side: bursts of ready with random stalls between them, and one
  // long hold-off on request so the block backs up into its input.
  initial begin : sink_ctl
    int unsigned gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldOffLen) @(posedge clk);
      end
      gap = pick_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #40_000_000;
    $display("bresenham_line_rasterizer test failed");
    $finish;
  end

  initial begin : main_seq
    line_cmd_t   directed[$];
    int unsigned run_w[NumRuns];
    int unsigned run_h[NumRuns];
    board        = new();
    calm         = 1'b0;
    hold_off_req = 1'b0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CfgCanvasWidth;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    start_x   <= '0;
    start_y   <= '0;
    end_x     <= '0;
    end_y     <= '0;
    fill_char <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines on the reset canvas: degenerate points at both corners,
    // full diagonals both ways, axis lines both ways, shallow and steep
    // extremes, and a few mixed slopes with extreme fill characters.
    directed.push_back(mk_line(0, 0, 0, 0, 0));
    directed.push_back(mk_line(63, 63, 63, 63, 255));
    directed.push_back(mk_line(0, 0, 63, 63, 8'h01));
    directed.push_back(mk_line(63, 63, 0, 0, 8'h80));
    directed.push_back(mk_line(0, 63, 63, 0, 8'hFE));
    directed.push_back(mk_line(63, 0, 0, 63, 8'h7F));
    directed.push_back(mk_line(0, 5, 63, 5, 8'h2A));
    directed.push_back(mk_line(63, 40, 0, 40, 8'h2B));
    directed.push_back(mk_line(7, 0, 7, 63, 8'h2C));
    directed.push_back(mk_line(7, 63, 7, 0, 8'h2D));
    directed.push_back(mk_line(0, 0, 63, 1, 8'h41));
    directed.push_back(mk_line(0, 0, 1, 63, 8'h42));
    directed.push_back(mk_line(63, 62, 0, 63, 8'h43));
    directed.push_back(mk_line(10, 20, 13, 50, 8'h44));
    directed.push_back(mk_line(50, 9, 2, 30, 8'h45));
    directed.push_back(mk_line(21, 42, 42, 21, 8'hAA));
    directed.push_back(mk_line(42, 21, 21, 42, 8'h55));
    directed.push_back(mk_line(30, 30, 31, 31, 8'h00));
    directed.push_back(mk_line(30, 30, 29, 30, 8'hFF));
    foreach (directed[i]) send_line(directed[i]);
    in_valid <= 1'b0;
    wait_drained();

    // Canvas sizes per run: reset size, zero width, zero height, both zero,
    // oversized, the smallest, width just above full size, then random sizes.
    run_w = '{64, 0, 64, 0, 127, 1, 65, $urandom_range(1, 64), $urandom_range(1, 64)};
    run_h = '{64, 64, 0, 0, 127, 1, 100, $urandom_range(1, 64), $urandom_range(1, 64)};

    for (int r = 0; r < NumRuns; r++) begin
      write_canvas(run_w[r], run_h[r]);
      // Run 1 streams with no idling; run 2 holds the receiver off while the
      // sender keeps offering; the last run idles nowhere either.
      calm = (r == 1) || (r == 2) || (r == NumRuns - 1);
      if (r == 2) hold_off_req = 1'b1;
      for (int i = 0; i < ItemsPerRun; i++) send_line(random_line());
      in_valid <= 1'b0;
      calm = 1'b0;
      wait_drained();
    end

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("bresenham_line_rasterizer test passed");
    end else begin
      $display("bresenham_line_rasterizer test failed");
    end
    $finish;
  end

endmodule
